[rtl/lrf_pkg.sv]
package lrf_pkg;

   localparam int SCREEN_WIDTH_DEF = 84;
   localparam int BANK_COUNT_DEF   = 6;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [2:0] BIT_MASK = 3'h7;

   typedef struct packed {
      logic       operation;
      logic [6:0] x_start;
      logic [5:0] y_start;
      logic [6:0] x_end;
      logic [5:0] y_end;
   } req_type;

   typedef struct packed {
      logic [6:0] column;
      logic [2:0] bank;
      logic [7:0] column_byte;
      logic       last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [6:0] x;
      logic [6:0] y;
      logic       last;
   } pixel_type;

endpackage

[rtl/lrf_stepper.sv]
module lrf_stepper
   import lrf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      step,
   input  req_type   req,
   output logic      active,
   output pixel_type pixel
);

   logic [6:0] major_pos_ff, major_pos_in;
   logic [6:0] minor_pos_ff, minor_pos_in;
   logic [6:0] pixels_left_ff, pixels_left_in;
   logic [7:0] error_acc_ff, error_acc_in;
   logic [6:0] major_delta_ff, major_delta_in;
   logic [6:0] minor_delta_ff, minor_delta_in;
   logic       x_is_major_ff, x_is_major_in;
   logic       major_dir_ff, major_dir_in;
   logic       minor_dir_ff, minor_dir_in;

   logic [6:0] dx;
   logic [6:0] dy;
   logic [7:0] e_sum;
   logic [9:0] e_twice;
   logic       minor_move;

   assign dx = (req.x_start >= req.x_end) ? (req.x_start - req.x_end)
                                          : (req.x_end - req.x_start);
   assign dy = {1'b0, (req.y_start >= req.y_end) ? (req.y_start - req.y_end)
                                                 : (req.y_end - req.y_start)};

   assign e_sum      = error_acc_ff + {1'b0, minor_delta_ff};
   assign e_twice    = {e_sum[7], e_sum, 1'b0};
   assign minor_move = $signed(e_twice) >= $signed({3'b000, major_delta_ff});

   assign active     = pixels_left_ff != 7'd0;
   assign pixel.x    = x_is_major_ff ? major_pos_ff : minor_pos_ff;
   assign pixel.y    = x_is_major_ff ? minor_pos_ff : major_pos_ff;
   assign pixel.last = pixels_left_ff == 7'd1;

   always_comb begin
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      pixels_left_in = pixels_left_ff;
      error_acc_in   = error_acc_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      x_is_major_in  = x_is_major_ff;
      major_dir_in   = major_dir_ff;
      minor_dir_in   = minor_dir_ff;
      if (start) begin
         error_acc_in = 8'd0;
         if (dx >= dy) begin
            x_is_major_in  = 1'b1;
            major_pos_in   = req.x_start;
            minor_pos_in   = {1'b0, req.y_start};
            major_delta_in = dx;
            minor_delta_in = dy;
            major_dir_in   = !(req.x_start < req.x_end);
            minor_dir_in   = !(req.y_end > req.y_start);
            pixels_left_in = dx;
         end else begin
            x_is_major_in  = 1'b0;
            major_pos_in   = {1'b0, req.y_start};
            minor_pos_in   = req.x_start;
            major_delta_in = dy;
            minor_delta_in = dx;
            major_dir_in   = !(req.y_start < req.y_end);
            minor_dir_in   = !(req.x_end > req.x_start);
            pixels_left_in = dy;
         end
      end else if (step) begin
         if (minor_move) begin
            minor_pos_in = minor_dir_ff ? minor_pos_ff - 7'd1 : minor_pos_ff + 7'd1;
            error_acc_in = e_sum - {1'b0, major_delta_ff};
         end else begin
            error_acc_in = e_sum;
         end
         major_pos_in   = major_dir_ff ? major_pos_ff - 7'd1 : major_pos_ff + 7'd1;
         pixels_left_in = pixels_left_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_pos_ff   <= '0;
         minor_pos_ff   <= '0;
         pixels_left_ff <= '0;
         error_acc_ff   <= '0;
         major_delta_ff <= '0;
         minor_delta_ff <= '0;
         x_is_major_ff  <= 1'b0;
         major_dir_ff   <= 1'b0;
         minor_dir_ff   <= 1'b0;
      end else begin
         major_pos_ff   <= major_pos_in;
         minor_pos_ff   <= minor_pos_in;
         pixels_left_ff <= pixels_left_in;
         error_acc_ff   <= error_acc_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         x_is_major_ff  <= x_is_major_in;
         major_dir_ff   <= major_dir_in;
         minor_dir_ff   <= minor_dir_in;
      end
   end

endmodule

[rtl/line_raster_to_framebuffer.sv]
// Channel  Ports                        Beat
// -------  ---------------------------  ------------------------------------
// request  req_valid req_stall req_data start (endpoints) or step command
// result   rsp_valid rsp_stall rsp_data column, bank, updated byte, last mark
//
// One beat per clock when not stalled: a step enters the line stepper, reads
// its column's row, and moves via the read stage to the output register.
// The store holds one row of all banks per column; a valid bit per column
// makes the store read as cleared after reset, with no clearing pass.
// A stall on the result side holds the read stage and stalls the request side.
module line_raster_to_framebuffer
   import lrf_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int BANK_COUNT   = BANK_COUNT_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
   localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

   logic      accept;
   logic      start;
   logic      step;
   logic      active;
   pixel_type pixel;
   logic      pixel_hit;

   logic                        s1_valid_ff;
   logic [6:0]                  s1_col_ff;
   logic [6:0]                  s1_y_ff;
   logic                        s1_hit_ff;
   logic                        s1_last_ff;
   logic                        s1_rvld_ff;
   logic [BANK_COUNT-1:0][7:0]  s1_rdata_ff;
   logic                        s1_go;

   logic [BANK_COUNT-1:0][7:0]  mem [SCREEN_WIDTH];
   logic [SCREEN_WIDTH-1:0]     row_vld_ff;

   logic                        fwd_valid_ff;
   logic [AW-1:0]               fwd_col_ff;
   logic [BANK_COUNT-1:0][7:0]  fwd_row_ff;

   logic [BANK_COUNT-1:0][7:0]  base_row;
   logic [BANK_COUNT-1:0][7:0]  new_row;
   logic [7:0]                  new_byte;
   logic [BW-1:0]               bank_sel;
   logic                        wr_en;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_data.operation == OP_START);
   assign step      = accept && (req_data.operation == OP_STEP) && active;

   lrf_stepper u_stepper (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .step   (step),
      .req    (req_data),
      .active (active),
      .pixel  (pixel)
   );

   assign pixel_hit = ({1'b0, pixel.x} < 8'(SCREEN_WIDTH)) &&
                      ({1'b0, pixel.y[6:3]} < 5'(BANK_COUNT));

   // read the column row at a step; write it back as an on-screen beat leaves
   always_ff @(posedge clock) begin
      if (step) begin
         s1_rdata_ff <= mem[pixel.x[AW-1:0]];
      end
      if (wr_en) begin
         mem[s1_col_ff[AW-1:0]] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_col_ff  <= pixel.x;
         s1_y_ff    <= pixel.y;
         s1_hit_ff  <= pixel_hit;
         s1_last_ff <= pixel.last;
         s1_rvld_ff <= row_vld_ff[pixel.x[AW-1:0]];
      end
      if (wr_en) begin
         fwd_col_ff <= s1_col_ff[AW-1:0];
         fwd_row_ff <= new_row;
      end
      if (s1_go) begin
         rsp_data_ff.column      <= s1_col_ff;
         rsp_data_ff.bank        <= s1_y_ff[5:3];
         rsp_data_ff.column_byte <= s1_hit_ff ? new_byte : 8'd0;
         rsp_data_ff.last_pixel  <= s1_last_ff;
      end
   end

   assign bank_sel = s1_y_ff[3 +: BW];
   assign wr_en    = s1_go && s1_hit_ff;

   always_comb begin
      if (fwd_valid_ff && (fwd_col_ff == s1_col_ff[AW-1:0])) begin
         base_row = fwd_row_ff;
      end else if (s1_rvld_ff) begin
         base_row = s1_rdata_ff;
      end else begin
         base_row = '0;
      end
      new_byte = base_row[bank_sel] | (8'd1 << (s1_y_ff[2:0] & BIT_MASK));
      new_row  = base_row;
      new_row[bank_sel] = new_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         if (step) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
            row_vld_ff[s1_col_ff[AW-1:0]] <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/sv/line_raster_to_framebuffer_test.sv]
module line_raster_to_framebuffer_test;
   import lrf_pkg::*;

   localparam int WIDTH          = SCREEN_WIDTH_DEF;
   localparam int BANKS          = BANK_COUNT_DEF;
   localparam int ROWS           = BANK_COUNT_DEF * 8;
   localparam int RANDOM_BEATS   = 1000;
   localparam int HOLD_AT_BEAT   = 300;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct {
      req_type beat;
      int      gap;
      bit      drain;
   } queued_beat_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   queued_beat_type beat_queue[$];
   rsp_type         pending_pixels[$];
   int              total_beats    = 0;
   int              mismatch_count = 0;
   int              req_count      = 0;
   int              rsp_count      = 0;
   int              idle_cycles    = 0;
   bit              req_taken      = 1'b0;
   bit              rsp_taken      = 1'b0;
   bit              sender_calm    = 1'b0;
   bit              drain_placed   = 1'b0;

   logic [7:0] frame [0:WIDTH*BANKS-1];
   logic [6:0] major_at, minor_at, steps_left, major_span, minor_span;
   logic [7:0] error_term;
   logic       x_major, major_down, minor_down;

   line_raster_to_framebuffer dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [6:0] span_of(logic [6:0] a, logic [6:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   task automatic trace_line_beat(req_type r);
      logic [6:0] dx, dy, px, py;
      logic [7:0] sum;
      int         e, idx;
      rsp_type    pixel;
      if (r.operation == OP_START) begin
         dx = span_of(r.x_start, r.x_end);
         dy = span_of({1'b0, r.y_start}, {1'b0, r.y_end});
         error_term = '0;
         x_major = (dx >= dy);
         if (x_major) begin
            major_at   = r.x_start;
            minor_at   = {1'b0, r.y_start};
            major_span = dx;
            minor_span = dy;
            major_down = !(r.x_start < r.x_end);
            minor_down = !(r.y_end > r.y_start);
         end else begin
            major_at   = {1'b0, r.y_start};
            minor_at   = r.x_start;
            major_span = dy;
            minor_span = dx;
            major_down = !(r.y_start < r.y_end);
            minor_down = !(r.x_end > r.x_start);
         end
         steps_left = major_span;
      end else if (steps_left != 0) begin
         px = x_major ? major_at : minor_at;
         py = x_major ? minor_at : major_at;
         pixel.column      = px;
         pixel.bank        = py[5:3];
         pixel.column_byte = '0;
         if (int'(px) < WIDTH && int'(py[6:3]) < BANKS) begin
            idx = int'(px) * BANKS + int'(py[6:3]);
            frame[idx][py[2:0]] = 1'b1;
            pixel.column_byte = frame[idx];
         end
         sum = error_term + {1'b0, minor_span};
         e = int'($signed(sum));
         if (2 * e >= int'(major_span)) begin
            minor_at = minor_down ? minor_at - 7'd1 : minor_at + 7'd1;
            e = e - int'(major_span);
         end
         error_term = e[7:0];
         major_at   = major_down ? major_at - 7'd1 : major_at + 7'd1;
         steps_left = steps_left - 7'd1;
         pixel.last_pixel = (steps_left == 0);
         pending_pixels.push_back(pixel);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_beat(logic op, int xs, int ys, int xe, int ye);
      queued_beat_type q;
      q.beat.operation = op;
      q.beat.x_start   = 7'(xs);
      q.beat.y_start   = 6'(ys);
      q.beat.x_end     = 7'(xe);
      q.beat.y_end     = 6'(ye);
      q.gap            = sender_calm ? 0 : $urandom_range(0, 12);
      q.drain          = 1'b0;
      beat_queue.push_back(q);
   endtask

   task automatic queue_step();
      queue_beat(OP_STEP, $urandom_range(0, 127), $urandom_range(0, 63),
                 $urandom_range(0, 127), $urandom_range(0, 63));
   endtask

   task automatic queue_random_line();
      int xs, ys, xe, ye, xmax, ymax, len, dy, steps;
      bit wide;
      wide = ($urandom_range(0, 4) == 0);
      xmax = wide ? 127 : WIDTH - 1;
      ymax = wide ? 63 : ROWS - 1;
      xs = $urandom_range(0, xmax);
      ys = $urandom_range(0, ymax);
      if ($urandom_range(0, 9) == 0) begin
         xe = $urandom_range(0, xmax);
         ye = $urandom_range(0, ymax);
      end else begin
         xe = xs + int'($urandom_range(0, 20)) - 10;
         ye = ys + int'($urandom_range(0, 20)) - 10;
         if (xe < 0) xe = 0;
         if (xe > xmax) xe = xmax;
         if (ye < 0) ye = 0;
         if (ye > ymax) ye = ymax;
      end
      len = (xs > xe) ? xs - xe : xe - xs;
      dy  = (ys > ye) ? ys - ye : ye - ys;
      if (dy > len) len = dy;
      if ($urandom_range(0, 4) == 0)
         steps = $urandom_range(0, len);
      else
         steps = len + $urandom_range(0, 2);
      queue_beat(OP_START, xs, ys, xe, ye);
      repeat (steps) queue_step();
   endtask

   // driver
   always @(negedge clock) begin
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (!reset) begin
         if (req_valid && req_taken) next_valid = 1'b0;
         if (!next_valid && beat_queue.size() != 0) begin
            if (beat_queue[0].drain && pending_pixels.size() != 0) begin
            end else if (beat_queue[0].gap != 0) begin
               beat_queue[0].gap = beat_queue[0].gap - 1;
            end else begin
               next_data  = beat_queue[0].beat;
               next_valid = 1'b1;
               void'(beat_queue.pop_front());
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // receiver
   always @(negedge clock) begin
      logic next_stall;
      bit   hold_done;
      int   hold_left;
      int   stall_left;
      if (!hold_done && req_count >= HOLD_AT_BEAT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (rsp_taken)
         stall_left = ((rsp_count / 150) % 3 == 0) ? 0 : $urandom_range(0, 12);
      if (hold_left != 0) begin
         next_stall = 1'b1;
         hold_left--;
      end else if (stall_left != 0) begin
         next_stall = 1'b1;
         stall_left--;
      end else begin
         next_stall = 1'b0;
      end
      if (reset) next_stall = 1'b0;
      rsp_stall <= next_stall;
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            trace_line_beat(req_data);
            req_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pending_pixels.size() == 0) begin
               report_mismatch("pixel beat with none expected, column",
                               int'(rsp_data.column), 0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_data.column !== want.column)
                  report_mismatch("column", int'(rsp_data.column),
                                  int'(want.column));
               if (rsp_data.bank !== want.bank)
                  report_mismatch("bank", int'(rsp_data.bank), int'(want.bank));
               if (rsp_data.column_byte !== want.column_byte)
                  report_mismatch("column_byte", int'(rsp_data.column_byte),
                                  int'(want.column_byte));
               if (rsp_data.last_pixel !== want.last_pixel)
                  report_mismatch("last_pixel", int'(rsp_data.last_pixel),
                                  int'(want.last_pixel));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("line_raster_to_framebuffer: mismatch");
            $finish;
         end
      end
   end

   initial begin
      foreach (frame[i]) frame[i] = '0;
      major_at   = '0;
      minor_at   = '0;
      steps_left = '0;
      major_span = '0;
      minor_span = '0;
      error_term = '0;
      x_major    = 1'b0;
      major_down = 1'b0;
      minor_down = 1'b0;

      queue_step();
      queue_beat(OP_START, 5, 5, 5, 5);
      queue_step();
      queue_beat(OP_START, 0, 0, 3, 0);
      repeat (4) queue_step();
      queue_beat(OP_START, 83, 47, 81, 44);
      repeat (3) queue_step();
      queue_beat(OP_START, 127, 63, 124, 60);
      repeat (3) queue_step();
      queue_beat(OP_START, 0, 0, 127, 63);
      repeat (2) queue_step();
      queue_beat(OP_START, 10, 10, 10, 12);
      repeat (2) queue_step();

      total_beats = beat_queue.size() + RANDOM_BEATS;
      while (beat_queue.size() < total_beats) begin
         sender_calm = ((beat_queue.size() / 120) % 3 == 0);
         if ($urandom_range(0, 19) == 0)
            queue_beat(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                       $urandom_range(0, 63), $urandom_range(0, 127),
                       $urandom_range(0, 63));
         else
            queue_random_line();
         if (!drain_placed && beat_queue.size() >= 600) begin
            beat_queue[$].drain = 1'b1;
            drain_placed = 1'b1;
         end
      end
      total_beats = beat_queue.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_count != total_beats) @(negedge clock);
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("line_raster_to_framebuffer: match");
      else
         $display("line_raster_to_framebuffer: mismatch");
      $finish;
   end

endmodule
